// ----- hdl/lcfe_pkg.sv -----
// Shared types, command codes and defaults for the lazy condition field encoder.
`timescale 1ns / 1ps
`default_nettype none

package lcfe_pkg;

    // Default number of condition fields
    localparam int NUM_FIELDS_DEF = 8;

    // Width of the field index on the ports
    localparam int FIELD_W = 3;

    // Command codes
    localparam logic [1:0] CMD_DEFER = 2'd0;
    localparam logic [1:0] CMD_EAGER = 2'd1;
    localparam logic [1:0] CMD_MAT   = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } lcfe_state_t;

    // Controller to datapath
    typedef struct packed {
        logic req_ready;
        logic load_req;
        logic write_shadow;
        logic clr_req_pend;
        logic scan_start;
        logic scan_emit;
        logic scan_advance;
    } lcfe_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       req_valid;
        logic [1:0] command;
        logic       idx_ok;
        logic       lazy;
        logic       out_free;
        logic       any_pending;
        logic       cur_pending;
        logic       last_pending;
        logic       scan_end;
    } lcfe_stat_t;

endpackage

`default_nettype wire

// ----- hdl/lcfe_if.sv -----
// Channel interfaces: request words, result words and the configuration write.
`timescale 1ns / 1ps
`default_nettype none

interface lcfe_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [2:0]         field_index;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic               record_form;
    logic               unsigned_compare;
    logic               so_bit;

    modport source (
        output valid, command, field_index, operand_a, operand_b,
               record_form, unsigned_compare, so_bit,
        input  ready
    );
    modport sink (
        input  valid, command, field_index, operand_a, operand_b,
               record_form, unsigned_compare, so_bit,
        output ready
    );
endinterface

interface lcfe_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_field;
    logic [63:0] cr_value;
    logic        last;

    modport source (
        output valid, out_field, cr_value, last,
        input  ready
    );
    modport sink (
        input  valid, out_field, cr_value, last,
        output ready
    );
endinterface

interface lcfe_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/lazy_condition_field_encoder.sv -----
// Top level of the lazy condition field encoder: controller, datapath, checks.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir   Word                                               Notes
// -------  ----  -------------------------------------------------  -------------------------
// req      in    command, field_index, operand_a/b, record_form,    defer / eager / materialize
//                unsigned_compare, so_bit
// rsp      out   out_field, cr_value, last                          zero or more per request
// cfg      in    data (lazy_enable)                                 write while idle only
//
// A new defer or eager word is taken every cycle as long as the result register
// is empty or being drained.
// Materialize walks the field store from field 0 up to the last pending one
// with the single shared encoder; req.ready is low during that walk.
// A stalled rsp holds the result register and stops decode; the walk stops
// at the next pending field.
// Reset clears pending flags, lazy_enable, state and rsp.valid; the shadow
// operand store is not reset.

module lazy_condition_field_encoder #(
    parameter int NUM_FIELDS = lcfe_pkg::NUM_FIELDS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    lcfe_req_if.sink    req,
    lcfe_rsp_if.source  rsp,
    lcfe_cfg_if.sink    cfg
);
    import lcfe_pkg::*;

    lcfe_cmd_t  cmd;    // controller commands
    lcfe_stat_t st;     // datapath status

    lcfe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    lcfe_dp #(
        .NUM_FIELDS (NUM_FIELDS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .st    (st)
    );

    // The walk never overwrites a result still waiting on rsp
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_emit |-> st.out_free)
        else $error("scan emitted into a busy result register");

    // The eager path and the walk never load the result register together
    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_req && cmd.scan_emit))
        else $error("two loads of the result register");

    // An accepted eager word shows up as a final result in the next cycle
    a_eager_out: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.command == CMD_EAGER && st.idx_ok)
        |=> (rsp.valid && rsp.last))
        else $error("eager word produced no final result");

    // A materialize with work to do closes the request side for the walk
    a_mat_block: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.command == CMD_MAT && st.any_pending)
        |=> !req.ready)
        else $error("request taken during materialize walk");

endmodule

`default_nettype wire

// ----- hdl/lcfe_ctrl.sv -----
// Controller state machine: request decode and the materialize scan sequence.
`timescale 1ns / 1ps
`default_nettype none

module lcfe_ctrl (
    input  wire                    clk,
    input  wire                    rst_n,
    input  lcfe_pkg::lcfe_stat_t   st,
    output lcfe_pkg::lcfe_cmd_t    cmd
);
    import lcfe_pkg::*;

    lcfe_state_t state_reg;
    lcfe_state_t state_next;
    logic        acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        acc        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.req_ready = st.out_free;
                acc           = st.req_valid && st.out_free;
                if (acc)
                begin
                    priority if (st.command == CMD_DEFER && st.idx_ok && st.lazy)
                    begin
                        cmd.write_shadow = 1'b1;
                    end
                    else if ((st.command == CMD_DEFER || st.command == CMD_EAGER)
                             && st.idx_ok)
                    begin
                        cmd.load_req     = 1'b1;
                        cmd.clr_req_pend = 1'b1;
                    end
                    else if (st.command == CMD_MAT && st.any_pending)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        // unknown code, bad index or nothing pending: drop
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (st.cur_pending)
                begin
                    if (st.out_free)
                    begin
                        cmd.scan_emit = 1'b1;
                        if (st.last_pending || st.scan_end)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.scan_advance = 1'b1;
                        end
                    end
                end
                else if (st.scan_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.scan_advance = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/lcfe_dp.sv -----
// Datapath: shadow field store, pending flags, shared encoder and result register.
`timescale 1ns / 1ps
`default_nettype none

module lcfe_dp #(
    parameter int NUM_FIELDS = lcfe_pkg::NUM_FIELDS_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    lcfe_req_if.sink               req,
    lcfe_rsp_if.source             rsp,
    lcfe_cfg_if.sink               cfg,
    input  lcfe_pkg::lcfe_cmd_t    cmd,
    output lcfe_pkg::lcfe_stat_t   st
);
    import lcfe_pkg::*;

    localparam int FIDX_W = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
    localparam int SO_POS = 27;
    localparam int LT_POS = 30;
    localparam int LE_POS = 31;

    function automatic logic [63:0] encode(
        input logic [31:0] a,
        input logic [31:0] b,
        input logic        rec,
        input logic        uns,
        input logic        so
    );
        logic        lt;
        logic        le;
        logic [31:0] lo;
        logic [31:0] hi;
        if (rec)
        begin
            lt = a[31];
            le = a[31] || (a == 32'd0);
            lo = a;
        end
        else if (uns)
        begin
            lt = a < b;
            le = a <= b;
            lo = a - b;
        end
        else
        begin
            lt = $signed(a) < $signed(b);
            le = $signed(a) <= $signed(b);
            lo = a - b;
        end
        hi         = 32'd1;
        hi[SO_POS] = so;
        hi[LT_POS] = lt;
        hi[LE_POS] = le;
        return {hi, lo};
    endfunction

    // shadow store, no reset: an entry is read only after its flag is set
    logic [31:0]           shadow_a_reg   [NUM_FIELDS];
    logic [31:0]           shadow_b_reg   [NUM_FIELDS];
    logic [1:0]            shadow_kind_reg[NUM_FIELDS];   // [1] record, [0] unsigned
    logic                  shadow_so_reg  [NUM_FIELDS];
    logic [NUM_FIELDS-1:0] pending_reg;
    logic [NUM_FIELDS-1:0] pending_next;
    logic [FIDX_W-1:0]     scan_idx_reg;
    logic                  lazy_reg;

    logic                  rsp_valid_reg;
    logic [FIELD_W-1:0]    out_field_reg;
    logic [63:0]           cr_value_reg;
    logic                  last_reg;

    logic [FIDX_W-1:0]     req_idx;
    logic                  above;
    logic [31:0]           enc_a;
    logic [31:0]           enc_b;
    logic                  enc_rec;
    logic                  enc_uns;
    logic                  enc_so;
    logic [63:0]           enc_value;

    assign req_idx   = req.field_index[FIDX_W-1:0];
    assign req.ready = cmd.req_ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.out_field = out_field_reg;
    assign rsp.cr_value  = cr_value_reg;
    assign rsp.last      = last_reg;

    // any pending field above the scan position
    always_comb
    begin
        above = 1'b0;
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            if (FIDX_W'(i) > scan_idx_reg && pending_reg[i])
            begin
                above = 1'b1;
            end
        end
    end

    always_comb
    begin
        st.req_valid    = req.valid;
        st.command      = req.command;
        st.idx_ok       = {1'b0, req.field_index} < (FIELD_W + 1)'(NUM_FIELDS);
        st.lazy         = lazy_reg;
        st.out_free     = !rsp_valid_reg || rsp.ready;
        st.any_pending  = |pending_reg;
        st.cur_pending  = pending_reg[scan_idx_reg];
        st.last_pending = !above;
        st.scan_end     = scan_idx_reg == FIDX_W'(NUM_FIELDS - 1);
    end

    // one encoder shared by the eager and non-lazy defer paths and the scan
    always_comb
    begin
        if (cmd.scan_emit)
        begin
            enc_a   = shadow_a_reg[scan_idx_reg];
            enc_b   = shadow_b_reg[scan_idx_reg];
            enc_rec = shadow_kind_reg[scan_idx_reg][1];
            enc_uns = shadow_kind_reg[scan_idx_reg][0];
            enc_so  = shadow_so_reg[scan_idx_reg];
        end
        else
        begin
            enc_a   = req.operand_a;
            enc_b   = req.operand_b;
            enc_rec = req.record_form;
            enc_uns = req.unsigned_compare;
            enc_so  = req.so_bit;
        end
        enc_value = encode(enc_a, enc_b, enc_rec, enc_uns, enc_so);
    end

    always_comb
    begin
        pending_next = pending_reg;
        if (cmd.write_shadow)
        begin
            pending_next[req_idx] = 1'b1;
        end
        if (cmd.clr_req_pend)
        begin
            pending_next[req_idx] = 1'b0;
        end
        if (cmd.scan_emit)
        begin
            pending_next[scan_idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_shadow)
        begin
            shadow_a_reg[req_idx]    <= req.operand_a;
            shadow_b_reg[req_idx]    <= req.operand_b;
            shadow_kind_reg[req_idx] <= {req.record_form, req.unsigned_compare};
            shadow_so_reg[req_idx]   <= req.so_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            out_field_reg <= req.field_index;
            cr_value_reg  <= enc_value;
            last_reg      <= 1'b1;
        end
        else if (cmd.scan_emit)
        begin
            out_field_reg <= FIELD_W'(scan_idx_reg);
            cr_value_reg  <= enc_value;
            last_reg      <= !above;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            scan_idx_reg  <= '0;
            lazy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (cfg.valid)
            begin
                lazy_reg <= cfg.data;
            end
            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_advance)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (cmd.load_req || cmd.scan_emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
